/* rtl/i2cm_pkg.sv */
// ----------------------------------------------------------------------------
// i2cm_pkg
// Shared types and constants for the I2C master transaction engine.
// ----------------------------------------------------------------------------
package i2cm_pkg;

  localparam logic [2:0] OP_RAW_WR = 3'd1;
  localparam logic [2:0] OP_RAW_RD = 3'd2;
  localparam logic [2:0] OP_REG_WR = 3'd3;
  localparam logic [2:0] OP_REG_RD = 3'd4;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_ADDR_NACK = 3'd1;
  localparam logic [2:0] ST_REG_NACK  = 3'd2;
  localparam logic [2:0] ST_RADR_NACK = 3'd3;
  localparam logic [2:0] ST_ZERO_CNT  = 3'd4;
  localparam logic [2:0] ST_DATA_NACK = 3'd5;

  localparam logic [4:0] PH_IDLE   = 5'd0;
  localparam logic [4:0] PH_ST1    = 5'd1;
  localparam logic [4:0] PH_ST2    = 5'd2;
  localparam logic [4:0] PH_ST3    = 5'd3;
  localparam logic [4:0] PH_RS0    = 5'd4;
  localparam logic [4:0] PH_RS1    = 5'd5;
  localparam logic [4:0] PH_RS2    = 5'd6;
  localparam logic [4:0] PH_RS3    = 5'd7;
  localparam logic [4:0] PH_ADR_LO = 5'd8;
  localparam logic [4:0] PH_ADR_HI = 5'd9;
  localparam logic [4:0] PH_REG_LO = 5'd10;
  localparam logic [4:0] PH_REG_HI = 5'd11;
  localparam logic [4:0] PH_RAD_LO = 5'd12;
  localparam logic [4:0] PH_RAD_HI = 5'd13;
  localparam logic [4:0] PH_WDT_LO = 5'd14;
  localparam logic [4:0] PH_WDT_HI = 5'd15;
  localparam logic [4:0] PH_RDT_LO = 5'd16;
  localparam logic [4:0] PH_RDT_HI = 5'd17;
  localparam logic [4:0] PH_SP0    = 5'd18;
  localparam logic [4:0] PH_SP1    = 5'd19;
  localparam logic [4:0] PH_SP2    = 5'd20;

  localparam logic [0:0] CFG_PHASE_TICKS   = 1'd0;
  localparam logic [0:0] CFG_STRETCH_LIMIT = 1'd1;

  typedef struct packed {
    logic [2:0] operation;
    logic [6:0] device_addr;
    logic [7:0] reg_addr;
    logic [7:0] byte_count;
    logic [7:0] write_data;
    logic       sda_in;
    logic       scl_in;
  } i2cm_req_t;

  typedef struct packed {
    logic       scl_release;
    logic       sda_release;
    logic [7:0] read_data;
    logic       read_valid;
    logic       read_last;
    logic       write_taken;
    logic       busy_res;
    logic       done_res;
    logic [2:0] status;
  } i2cm_rsp_t;

endpackage

/* rtl/i2c_master_transaction_engine.sv */
// ----------------------------------------------------------------------------
// i2c_master_transaction_engine
// Tick-stepped I2C master: command sequencing, open-drain line drive, results.
// ----------------------------------------------------------------------------
// Each accepted request is one bus timing tick. The tick passes through one
// register stage into the sequencer, which updates its state and forms one
// response in the same step; the response is held in an output register.
// One request is taken every clock while the output side keeps up; when the
// output register is full and not taken, the input register holds and in_ready_o
// drops, so no request is lost.
module i2c_master_transaction_engine
  import i2cm_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [0:0]  cfg_idx_i,
  input  logic [15:0] cfg_data_i,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  i2cm_req_t   in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output i2cm_rsp_t   out_data_o
);

  logic [15:0] phase_ticks_q;
  logic [7:0]  stretch_limit_q;

  logic [4:0]  phase_q, phase_d;
  logic [3:0]  bit_index_q, bit_index_d;
  logic [7:0]  shift_byte_q, shift_byte_d;
  logic [7:0]  bytes_left_q, bytes_left_d;
  logic [15:0] tick_count_q, tick_count_d;
  logic [7:0]  stretch_count_q, stretch_count_d;
  logic [2:0]  active_mode_q, active_mode_d;
  logic [6:0]  held_device_q, held_device_d;
  logic [7:0]  held_register_q, held_register_d;
  logic [2:0]  result_code_q, result_code_d;

  logic        in_vld_q;
  i2cm_req_t   in_q;
  logic        out_vld_q;
  i2cm_rsp_t   out_q;
  i2cm_rsp_t   rsp;
  logic        step;

  // The stage register moves only when the output register can take its result.
  assign step       = in_vld_q && (!out_vld_q || out_ready_i);
  assign in_ready_o = !in_vld_q || step;
  assign out_valid_o = out_vld_q;
  assign out_data_o  = out_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_ticks_q   <= 16'd125;
      stretch_limit_q <= 8'd255;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_PHASE_TICKS:   phase_ticks_q   <= cfg_data_i;
        CFG_STRETCH_LIMIT: stretch_limit_q <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_vld_q <= 1'b0;
    end else if (in_ready_o) begin
      in_vld_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_q <= in_data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (step) begin
      out_vld_q <= 1'b1;
    end else if (out_ready_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_q <= rsp;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q         <= PH_IDLE;
      bit_index_q     <= '0;
      shift_byte_q    <= '0;
      bytes_left_q    <= '0;
      tick_count_q    <= '0;
      stretch_count_q <= '0;
      active_mode_q   <= '0;
      held_device_q   <= '0;
      held_register_q <= '0;
      result_code_q   <= ST_OK;
    end else if (step) begin
      phase_q         <= phase_d;
      bit_index_q     <= bit_index_d;
      shift_byte_q    <= shift_byte_d;
      bytes_left_q    <= bytes_left_d;
      tick_count_q    <= tick_count_d;
      stretch_count_q <= stretch_count_d;
      active_mode_q   <= active_mode_d;
      held_device_q   <= held_device_d;
      held_register_q <= held_register_d;
      result_code_q   <= result_code_d;
    end
  end

  function automatic logic scl_of(logic [4:0] ph);
    logic r;
    r = 1'b1;
    case (ph)
      PH_ST3, PH_RS0, PH_RS3, PH_SP0: r = 1'b0;
      default: begin
        if (ph >= PH_ADR_LO && ph <= PH_RDT_HI) r = ph[0];
      end
    endcase
    return r;
  endfunction

  function automatic logic sda_of(logic [4:0] ph, logic [3:0] bi, logic [7:0] sb,
                                  logic [7:0] bl);
    logic r;
    r = 1'b1;
    case (ph)
      PH_ST2, PH_ST3, PH_RS2, PH_RS3, PH_SP0, PH_SP1: r = 1'b0;
      default: begin
        if (ph >= PH_ADR_LO && ph <= PH_WDT_HI) r = bi[3] ? 1'b1 : sb[7];
        else if (ph == PH_RDT_LO || ph == PH_RDT_HI) r = bi[3] ? (bl <= 8'd1) : 1'b1;
      end
    endcase
    return r;
  endfunction

  logic [4:0]  ph;
  logic [15:0] pt;
  logic [16:0] nxt;
  logic [4:0]  lo;
  logic        sda, rvld, rlast, wtk, done;
  logic [7:0]  rdat, bl_dec;

  always_comb begin
    phase_d         = phase_q;
    bit_index_d     = bit_index_q;
    shift_byte_d    = shift_byte_q;
    bytes_left_d    = bytes_left_q;
    tick_count_d    = tick_count_q;
    stretch_count_d = stretch_count_q;
    active_mode_d   = active_mode_q;
    held_device_d   = held_device_q;
    held_register_d = held_register_q;
    result_code_d   = result_code_q;
    rvld = 1'b0; rlast = 1'b0; wtk = 1'b0; done = 1'b0; rdat = '0;
    sda  = in_q.sda_in;
    pt   = (phase_ticks_q == 16'd0) ? 16'd1 : phase_ticks_q;
    nxt  = {1'b0, tick_count_q} + 17'd1;
    lo   = {phase_q[4:1], 1'b0};
    bl_dec = (bytes_left_q != 8'd0) ? bytes_left_q - 8'd1 : 8'd0;

    ph = (phase_q > PH_SP2) ? PH_IDLE : phase_q;
    if (phase_q > PH_SP2) begin
      phase_d = PH_IDLE;
      tick_count_d = '0;
      stretch_count_d = '0;
    end

    if (ph == PH_IDLE) begin
      if (in_q.operation >= OP_RAW_WR && in_q.operation <= OP_REG_RD) begin
        active_mode_d   = in_q.operation;
        held_device_d   = in_q.device_addr;
        held_register_d = in_q.reg_addr;
        bytes_left_d    = in_q.byte_count;
        result_code_d   = ST_OK;
        bit_index_d     = '0;
        shift_byte_d    = '0;
        phase_d         = PH_ST1;
        tick_count_d    = '0;
        stretch_count_d = '0;
      end
    end else if (scl_of(ph) && !in_q.scl_in && stretch_count_q < stretch_limit_q) begin
      stretch_count_d = stretch_count_q + 8'd1;
    end else if (nxt < {1'b0, pt}) begin
      tick_count_d = nxt[15:0];
    end else begin
      // Phase ends: every branch below restarts the tick and stretch counters.
      tick_count_d    = '0;
      stretch_count_d = '0;
      case (ph)
        PH_ST1: phase_d = PH_ST2;
        PH_ST2: phase_d = PH_ST3;
        PH_ST3: begin
          phase_d = PH_ADR_LO; bit_index_d = '0;
          shift_byte_d = {held_device_q, active_mode_q == OP_RAW_RD};
        end
        PH_RS0: phase_d = PH_RS1;
        PH_RS1: phase_d = PH_RS2;
        PH_RS2: phase_d = PH_RS3;
        PH_RS3: begin
          phase_d = PH_RAD_LO; bit_index_d = '0;
          shift_byte_d = {held_device_q, 1'b1};
        end
        PH_SP0: phase_d = PH_SP1;
        PH_SP1: phase_d = PH_SP2;
        PH_SP2: begin
          phase_d = PH_IDLE; done = 1'b1;
        end
        default: begin
          if (!ph[0]) begin
            phase_d = ph + 5'd1;
          end else if (!bit_index_q[3]) begin
            shift_byte_d = {shift_byte_q[6:0], (lo == PH_RDT_LO) ? sda : 1'b0};
            bit_index_d  = bit_index_q + 4'd1;
            phase_d      = lo;
          end else begin
            // Acknowledge slot: default to next byte load, override for stop.
            bit_index_d = '0;
            case (lo)
              PH_RDT_LO: begin
                rdat = shift_byte_q; rvld = 1'b1;
                rlast = (bytes_left_q <= 8'd1);
                bytes_left_d = bl_dec;
                if (bl_dec == 8'd0) phase_d = PH_SP0;
                else begin phase_d = PH_RDT_LO; shift_byte_d = '0; end
              end
              PH_ADR_LO: begin
                if (sda) begin
                  phase_d = PH_SP0; result_code_d = ST_ADDR_NACK;
                end else if (active_mode_q == OP_RAW_WR) begin
                  if (bytes_left_q == 8'd0) begin
                    phase_d = PH_SP0; result_code_d = ST_OK;
                  end else begin
                    phase_d = PH_WDT_LO; shift_byte_d = in_q.write_data; wtk = 1'b1;
                  end
                end else if (active_mode_q == OP_RAW_RD) begin
                  if (bytes_left_q == 8'd0) begin
                    phase_d = PH_SP0; result_code_d = ST_ZERO_CNT;
                  end else begin
                    phase_d = PH_RDT_LO; shift_byte_d = '0;
                  end
                end else begin
                  phase_d = PH_REG_LO; shift_byte_d = held_register_q;
                end
              end
              PH_REG_LO: begin
                if (sda) begin
                  phase_d = PH_SP0; result_code_d = ST_REG_NACK;
                end else if (active_mode_q == OP_REG_RD) begin
                  phase_d = PH_RS0;
                end else if (bytes_left_q == 8'd0) begin
                  phase_d = PH_SP0; result_code_d = ST_OK;
                end else begin
                  phase_d = PH_WDT_LO; shift_byte_d = in_q.write_data; wtk = 1'b1;
                end
              end
              PH_RAD_LO: begin
                if (sda) begin
                  phase_d = PH_SP0; result_code_d = ST_RADR_NACK;
                end else if (bytes_left_q == 8'd0) begin
                  phase_d = PH_SP0; result_code_d = ST_ZERO_CNT;
                end else begin
                  phase_d = PH_RDT_LO; shift_byte_d = '0;
                end
              end
              default: begin
                if (sda) begin
                  phase_d = PH_SP0; result_code_d = ST_DATA_NACK;
                end else begin
                  bytes_left_d = bl_dec;
                  if (bl_dec == 8'd0) begin
                    phase_d = PH_SP0; result_code_d = ST_OK;
                  end else begin
                    phase_d = PH_WDT_LO; shift_byte_d = in_q.write_data; wtk = 1'b1;
                  end
                end
              end
            endcase
          end
        end
      endcase
    end

    rsp.scl_release = scl_of(phase_d);
    rsp.sda_release = sda_of(phase_d, bit_index_d, shift_byte_d, bytes_left_d);
    rsp.read_data   = rdat;
    rsp.read_valid  = rvld;
    rsp.read_last   = rlast;
    rsp.write_taken = wtk;
    rsp.busy_res    = (phase_d != PH_IDLE);
    rsp.done_res    = done;
    rsp.status      = result_code_d;
  end

`ifndef ASSERT_OFF
  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step && rsp.done_res |-> !rsp.busy_res) else $error("done while busy");
  a_bit_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    bit_index_q <= 4'd8) else $error("bit index out of range");
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_vld_q && !out_ready_i |=> out_vld_q && $stable(out_q)) else $error("output lost");
  a_rd_wr: assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |-> !(rsp.read_valid && rsp.write_taken)) else $error("read and write at once");
`endif

endmodule

/* tb/sv/tb_i2c_master_transaction_engine.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_i2c_master_transaction_engine
// Tick-level check of the I2C master transaction engine. Every request is one
// bus tick; a built-in sequencer model predicts the response of each tick and
// the monitor compares every response field against it, in order.
// ----------------------------------------------------------------------------
module tb_i2c_master_transaction_engine;
  import i2cm_pkg::*;

  localparam int unsigned CYCLE_LIMIT = 2000000;

  logic        clk_i;
  logic        rst_ni;
  logic        cfg_we_i;
  logic [0:0]  cfg_idx_i;
  logic [15:0] cfg_data_i;
  logic        in_valid_i;
  logic        in_ready_o;
  i2cm_req_t   in_data_i;
  logic        out_valid_o;
  logic        out_ready_i;
  i2cm_rsp_t   out_data_o;

  i2c_master_transaction_engine u_dut (.*);

  always begin
    clk_i = 1'b1; #2;
    clk_i = 1'b0; #2;
  end

  // Sequencer model state
  logic [15:0] m_phase_ticks;
  logic [7:0]  m_stretch_limit;
  logic [4:0]  m_phase;
  logic [3:0]  m_bit;
  logic [7:0]  m_shift;
  logic [7:0]  m_left;
  logic [15:0] m_tick;
  logic [7:0]  m_stretch;
  logic [2:0]  m_mode;
  logic [6:0]  m_dev;
  logic [7:0]  m_reg;
  logic [2:0]  m_code;
  i2cm_rsp_t   m_ev;

  i2cm_req_t   pending_reqs[$];
  i2cm_rsp_t   expected_rsps[$];
  int unsigned errors = 0;
  int unsigned rsp_count = 0;
  int unsigned done_count = 0;
  int unsigned read_bytes = 0;
  int unsigned cycles = 0;
  int unsigned queued = 0;
  int unsigned hold_req = 0;

  // Bus-level byte sequence driving: the slave-side line levels are random
  // but biased so most transactions get acked and run to completion.
  int unsigned nack_pct;
  int unsigned low_scl_pct;

  function automatic void enter(input logic [4:0] p);
    m_phase = p;
    m_tick = '0;
    m_stretch = '0;
  endfunction

  function automatic void load(input logic [4:0] p, input logic [7:0] v);
    m_shift = v;
    m_bit = '0;
    enter(p);
  endfunction

  function automatic void to_stop(input logic [2:0] c);
    m_code = c;
    m_bit = '0;
    enter(PH_SP0);
  endfunction

  function automatic void take_write(input logic [7:0] wd);
    load(PH_WDT_LO, wd);
    m_ev.write_taken = 1'b1;
  endfunction

  function automatic logic scl_level();
    if (m_phase inside {PH_ST3, PH_RS0, PH_RS3, PH_SP0}) return 1'b0;
    if (m_phase >= PH_ADR_LO && m_phase <= PH_RDT_HI) return m_phase[0];
    return 1'b1;
  endfunction

  function automatic logic sda_level();
    if (m_phase inside {PH_ST2, PH_ST3, PH_RS2, PH_RS3, PH_SP0, PH_SP1}) return 1'b0;
    if (m_phase >= PH_ADR_LO && m_phase <= PH_WDT_HI)
      return m_bit < 8 ? m_shift[7] : 1'b1;
    if (m_phase >= PH_RDT_LO && m_phase <= PH_RDT_HI)
      return m_bit < 8 ? 1'b1 : (m_left > 1 ? 1'b0 : 1'b1);
    return 1'b1;
  endfunction

  function automatic void byte_acked(input logic [4:0] lo, input logic sda,
                                     input logic [7:0] wd);
    if (lo == PH_RDT_LO) begin
      m_ev.read_data = m_shift;
      m_ev.read_valid = 1'b1;
      m_ev.read_last = m_left <= 1;
      if (m_left > 0) m_left = m_left - 1;
      if (m_left == 0) to_stop(m_code);
      else load(PH_RDT_LO, 8'h00);
    end else if (lo == PH_ADR_LO) begin
      if (sda) to_stop(ST_ADDR_NACK);
      else if (m_mode == OP_RAW_WR) begin
        if (m_left == 0) to_stop(ST_OK); else take_write(wd);
      end else if (m_mode == OP_RAW_RD) begin
        if (m_left == 0) to_stop(ST_ZERO_CNT); else load(PH_RDT_LO, 8'h00);
      end else load(PH_REG_LO, m_reg);
    end else if (lo == PH_REG_LO) begin
      if (sda) to_stop(ST_REG_NACK);
      else if (m_mode == OP_REG_RD) begin
        m_bit = '0;
        enter(PH_RS0);
      end else if (m_left == 0) to_stop(ST_OK);
      else take_write(wd);
    end else if (lo == PH_RAD_LO) begin
      if (sda) to_stop(ST_RADR_NACK);
      else if (m_left == 0) to_stop(ST_ZERO_CNT);
      else load(PH_RDT_LO, 8'h00);
    end else begin
      if (sda) to_stop(ST_DATA_NACK);
      else begin
        if (m_left > 0) m_left = m_left - 1;
        if (m_left == 0) to_stop(ST_OK); else take_write(wd);
      end
    end
  endfunction

  function automatic void phase_end(input logic sda, input logic [7:0] wd);
    logic [4:0] lo;
    case (m_phase)
      PH_ST1: enter(PH_ST2);
      PH_ST2: enter(PH_ST3);
      PH_ST3: load(PH_ADR_LO, {m_dev, m_mode == OP_RAW_RD});
      PH_RS0: enter(PH_RS1);
      PH_RS1: enter(PH_RS2);
      PH_RS2: enter(PH_RS3);
      PH_RS3: load(PH_RAD_LO, {m_dev, 1'b1});
      PH_SP0: enter(PH_SP1);
      PH_SP1: enter(PH_SP2);
      PH_SP2: begin
        m_ev.done_res = 1'b1;
        enter(PH_IDLE);
      end
      default: begin
        if (m_phase < PH_ADR_LO || m_phase > PH_RDT_HI) enter(PH_IDLE);
        else if (!m_phase[0]) enter(m_phase + 5'd1);
        else begin
          lo = m_phase - 5'd1;
          if (m_bit < 8) begin
            m_shift = (lo == PH_RDT_LO) ? {m_shift[6:0], sda} : {m_shift[6:0], 1'b0};
            m_bit = m_bit + 4'd1;
            enter(lo);
          end else byte_acked(lo, sda, wd);
        end
      end
    endcase
  endfunction

  function automatic i2cm_rsp_t predict_tick(input i2cm_req_t r);
    int unsigned pt;
    int unsigned nxt;
    pt = (m_phase_ticks == 0) ? 1 : m_phase_ticks;
    m_ev = '0;
    if (m_phase > PH_SP2) enter(PH_IDLE);
    if (m_phase == PH_IDLE) begin
      if (r.operation >= OP_RAW_WR && r.operation <= OP_REG_RD) begin
        m_mode = r.operation;
        m_dev = r.device_addr;
        m_reg = r.reg_addr;
        m_left = r.byte_count;
        m_code = ST_OK;
        m_bit = '0;
        m_shift = '0;
        enter(PH_ST1);
      end
    end else if (scl_level() && !r.scl_in && m_stretch < m_stretch_limit) begin
      m_stretch = m_stretch + 8'd1;
    end else begin
      nxt = m_tick + 1;
      if (nxt >= pt) phase_end(r.sda_in, r.write_data);
      else m_tick = nxt[15:0];
    end
    m_ev.scl_release = scl_level();
    m_ev.sda_release = sda_level();
    m_ev.busy_res = m_phase != PH_IDLE;
    m_ev.status = m_code;
    return m_ev;
  endfunction

  // Build one tick request. The model is stepped here as well, so the slave
  // reply (ack/nack, data bits) can react to the predicted bus phase.
  task automatic queue_tick(input logic [2:0] op, input logic [6:0] dev,
                            input logic [7:0] ra, input logic [7:0] cnt);
    i2cm_req_t r;
    r.operation = op;
    r.device_addr = dev;
    r.reg_addr = ra;
    r.byte_count = cnt;
    r.write_data = 8'($urandom_range(255));
    r.sda_in = ($urandom_range(99) < nack_pct) ? 1'b1 :
               ((m_phase == PH_RDT_HI && m_bit < 8) ? 1'($urandom_range(1)) : 1'b0);
    r.scl_in = ($urandom_range(99) < low_scl_pct) ? 1'b0 : 1'b1;
    expected_rsps.push_back(predict_tick(r));
    pending_reqs.push_back(r);
    queued++;
  endtask

  // Ticks until the model is idle again; random noise commands while busy.
  task automatic run_command(input logic [2:0] op, input logic [6:0] dev,
                             input logic [7:0] ra, input logic [7:0] cnt);
    queue_tick(op, dev, ra, cnt);
    while (m_phase != PH_IDLE)
      queue_tick(3'($urandom_range(7)), 7'($urandom_range(127)), 8'($urandom_range(255)),
                 8'($urandom_range(255)));
    queue_tick(3'd0, '0, '0, '0);
  endtask

  task automatic wait_drained();
    while (pending_reqs.size() != 0 || expected_rsps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [0:0] idx, input logic [15:0] val);
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_idx_i <= idx;
    cfg_data_i <= val;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == CFG_PHASE_TICKS) m_phase_ticks = val;
    else m_stretch_limit = val[7:0];
  endtask

  task automatic report_mismatch(input string what, input int unsigned got,
                                 input int unsigned want);
    errors++;
    $display("mismatch at response %0d: %s got %0h expected %0h",
             rsp_count, what, got, want);
  endtask

  // Driver
  int unsigned gap;
  bit          in_acc;

  // Note each accepting edge for the driver to act on at the next falling edge
  always @(posedge clk_i) begin
    in_acc <= rst_ni && in_valid_i && in_ready_o;
  end

  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
      in_data_i <= '0;
      gap = 0;
    end else begin
      if (in_acc) void'(pending_reqs.pop_front());
      if (in_valid_i && !in_acc) begin
        // hold
      end else if (gap != 0) begin
        gap--;
        in_valid_i <= 1'b0;
      end else if (pending_reqs.size() != 0) begin
        in_valid_i <= 1'b1;
        in_data_i <= pending_reqs[0];
        gap = ($urandom_range(99) < 70) ? 0 :
              ($urandom_range(99) < 90) ? $urandom_range(3) : $urandom_range(40);
      end else in_valid_i <= 1'b0;
    end
  end

  // Receiver stall pattern, with a long hold-off counted here on request
  int unsigned hold_off = 0;
  int unsigned hold_seen = 0;
  always @(negedge clk_i or negedge rst_ni) begin
    if (!rst_ni) out_ready_i <= 1'b0;
    else if (hold_req != hold_seen) begin
      hold_seen = hold_req;
      hold_off = 300;
      out_ready_i <= 1'b0;
    end else if (hold_off != 0) begin
      hold_off--;
      out_ready_i <= 1'b0;
    end else
      out_ready_i <= ($urandom_range(99) < 75) ? 1'b1 :
                     ($urandom_range(99) < 3 ? 1'b0 : 1'($urandom_range(1)));
  end

  // Monitor
  i2cm_rsp_t want;
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (expected_rsps.size() == 0) report_mismatch("unexpected response", 1, 0);
      else begin
        want = expected_rsps.pop_front();
        if (out_data_o.scl_release !== want.scl_release)
          report_mismatch("scl_release", out_data_o.scl_release, want.scl_release);
        if (out_data_o.sda_release !== want.sda_release)
          report_mismatch("sda_release", out_data_o.sda_release, want.sda_release);
        if (out_data_o.read_data !== want.read_data)
          report_mismatch("read_data", out_data_o.read_data, want.read_data);
        if (out_data_o.read_valid !== want.read_valid)
          report_mismatch("read_valid", out_data_o.read_valid, want.read_valid);
        if (out_data_o.read_last !== want.read_last)
          report_mismatch("read_last", out_data_o.read_last, want.read_last);
        if (out_data_o.write_taken !== want.write_taken)
          report_mismatch("write_taken", out_data_o.write_taken, want.write_taken);
        if (out_data_o.busy_res !== want.busy_res)
          report_mismatch("busy_res", out_data_o.busy_res, want.busy_res);
        if (out_data_o.done_res !== want.done_res)
          report_mismatch("done_res", out_data_o.done_res, want.done_res);
        if (out_data_o.status !== want.status)
          report_mismatch("status", out_data_o.status, want.status);
        if (want.done_res) done_count++;
        if (want.read_valid) read_bytes++;
      end
      rsp_count++;
    end
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    int unsigned n;
    logic [2:0] op;
    rst_ni = 1'b0;
    cfg_we_i = 1'b0;
    cfg_idx_i = '0;
    cfg_data_i = '0;
    m_phase_ticks = 16'd125;
    m_stretch_limit = 8'd255;
    m_phase = PH_IDLE; m_bit = '0; m_shift = '0; m_left = '0; m_tick = '0;
    m_stretch = '0; m_mode = '0; m_dev = '0; m_reg = '0; m_code = '0;
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    // Directed: short phases, every operation, zero counts, nacks, field extremes
    nack_pct = 0;
    low_scl_pct = 0;
    write_cfg(CFG_PHASE_TICKS, 16'd0);
    write_cfg(CFG_STRETCH_LIMIT, 16'd0);
    run_command(OP_RAW_WR, 7'h7f, 8'hff, 8'd1);
    run_command(OP_RAW_RD, 7'h00, 8'h00, 8'd2);
    run_command(OP_REG_WR, 7'h55, 8'ha5, 8'd0);
    run_command(OP_REG_RD, 7'h2a, 8'h5a, 8'd0);
    run_command(OP_RAW_RD, 7'h11, 8'h00, 8'd0);
    run_command(OP_REG_RD, 7'h33, 8'h80, 8'd3);
    nack_pct = 100;
    run_command(OP_RAW_WR, 7'h01, 8'h01, 8'hff);
    queue_tick(3'd7, 7'h7f, 8'hff, 8'hff);
    queue_tick(3'd5, 7'h7f, 8'hff, 8'hff);
    wait_drained();

    // Random phases through several register settings, extremes included
    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: begin write_cfg(CFG_PHASE_TICKS, 16'd1); write_cfg(CFG_STRETCH_LIMIT, 16'd255); end
        1: begin write_cfg(CFG_PHASE_TICKS, 16'd2); write_cfg(CFG_STRETCH_LIMIT, 16'd3); end
        2: begin write_cfg(CFG_PHASE_TICKS, 16'd1); write_cfg(CFG_STRETCH_LIMIT, 16'd0); end
        3: begin write_cfg(CFG_PHASE_TICKS, 16'hffff); write_cfg(CFG_STRETCH_LIMIT, 16'd1); end
        4: begin write_cfg(CFG_PHASE_TICKS, 16'd3); write_cfg(CFG_STRETCH_LIMIT, 16'd7); end
        default: begin write_cfg(CFG_PHASE_TICKS, 16'd1); write_cfg(CFG_STRETCH_LIMIT, 16'd2); end
      endcase
      if (ph == 1) hold_req++;
      n = queued;
      if (ph == 3) begin
        // huge phase: forty ticks only, then drain and finish the transaction
        nack_pct = 0;
        low_scl_pct = 50;
        for (int k = 0; k < 40; k++) queue_tick(OP_RAW_WR, 7'($urandom_range(127)), 8'h00, 8'd1);
        wait_drained();
        // finish the long transaction quickly with a shorter phase setting
        write_cfg(CFG_PHASE_TICKS, 16'd1);
        while (m_phase != PH_IDLE) queue_tick(3'd0, '0, '0, '0);
      end else begin
        while (queued < n + 80) begin
          nack_pct = ($urandom_range(99) < 70) ? 0 : $urandom_range(15);
          low_scl_pct = ($urandom_range(99) < 50) ? 0 : $urandom_range(40);
          op = ($urandom_range(99) < 90) ? 3'($urandom_range(OP_REG_RD, OP_RAW_WR))
                                         : 3'($urandom_range(7));
          run_command(op, 7'($urandom_range(127)), 8'($urandom_range(255)),
                      8'($urandom_range(3)));
        end
      end
      wait_drained();
    end
    wait_drained();
    $display("checked %0d tick responses: %0d transactions completed, %0d bytes read",
             rsp_count, done_count, read_bytes);
    $display("covered all four commands, nacks, zero counts, stretch timeouts, stalls");
    if (errors == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule
